>>> hdl/cccd_pkg.sv
// Shared types, constants and the CRC-32C byte step for the frame deframer.
// Depends on nothing; the design files refer to it by scoped names.
`default_nettype none
package cccd_pkg;

    localparam int HEADER_BYTES    = 32;
    localparam int CRC_COVER_BYTES = 28;
    localparam int TRAILER_BYTES   = 4;
    localparam int TOTAL_W         = 25;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAGIC    = 2'd0;
    localparam logic [1:0] CFG_VERSION  = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd2;
    localparam logic [1:0] CFG_MAX_TYPE = 2'd3;

    localparam logic [31:0] RST_MAGIC    = 32'd0;
    localparam logic [15:0] RST_VERSION  = 16'd1;
    localparam logic [24:0] RST_MAX_LEN  = 25'd16777216;
    localparam logic [15:0] RST_MAX_TYPE = 16'd16;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_TRUNCATED   = 3'd1;
    localparam t_status ST_BAD_MAGIC   = 3'd2;
    localparam t_status ST_HEADER_CRC  = 3'd3;
    localparam t_status ST_TOO_LONG    = 3'd4;
    localparam t_status ST_VERSION     = 3'd5;
    localparam t_status ST_TYPE_TRAIL  = 3'd6;
    localparam t_status ST_PAYLOAD_CRC = 3'd7;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         payload_byte;
        t_status            frame_status;
        logic [15:0]        message_type;
        logic [31:0]        frame_flags;
        logic [63:0]        sequence_number;
        logic [TOTAL_W-1:0] frame_total_bytes;
        logic               last_of_frame;
    } t_result;

    // Reflected CRC-32C update by one byte
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/cccd_if.sv
// Valid/ready channel interfaces for the deframer byte input and result output.
// Depends on cccd_pkg for the status type and field widths.
`default_nettype none
interface cccd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;
    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface cccd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [7:0]                  payload_byte;
    cccd_pkg::t_status           frame_status;
    logic [15:0]                 message_type;
    logic [31:0]                 frame_flags;
    logic [63:0]                 sequence_number;
    logic [cccd_pkg::TOTAL_W-1:0] frame_total_bytes;
    logic                        last_of_frame;
    modport source (output valid, output result_kind, output payload_byte,
                    output frame_status, output message_type, output frame_flags,
                    output sequence_number, output frame_total_bytes,
                    output last_of_frame, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_status, input message_type, input frame_flags,
                    input sequence_number, input frame_total_bytes,
                    input last_of_frame, output ready);
endinterface
`default_nettype wire

>>> hdl/cccd_front.sv
// Front end: holds configuration, parses header/payload/trailer, classifies
// each byte and builds result entries. Depends on cccd_pkg.
`default_nettype none
module cccd_front #(
    parameter int PAYLOAD_LENGTH_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_buffer_end,
    output logic                   o_ready,
    input  wire logic              i_space,
    output logic                   o_push,
    output cccd_pkg::t_result      o_result
);
    localparam int POS_W = PAYLOAD_LENGTH_BITS + 1;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PAYLOAD, PH_TRAILER, PH_DONE, PH_EXTRA, PH_DISCARD
    } t_phase;

    logic [31:0] r_cfg_magic;
    logic [15:0] r_cfg_version;
    logic [24:0] r_cfg_max_len;
    logic [15:0] r_cfg_max_type;

    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_pay_end, n_pay_end;
    logic [POS_W-1:0]  r_trl_end, n_trl_end;
    logic [31:0]       r_magic, n_magic;
    logic [15:0]       r_ver, n_ver;
    logic [15:0]       r_type, n_type;
    logic [31:0]       r_flags, n_flags;
    logic [63:0]       r_seq, n_seq;
    logic [31:0]       r_len, n_len;
    logic [31:0]       r_hcrc, n_hcrc;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_trailer, n_trailer;
    cccd_pkg::t_status r_defer, n_defer;

    logic              accept;
    logic              fwd;
    logic [4:0]        hp;
    logic [2:0]        seq_lane;
    logic [32:0]       len_cap;
    logic [32:0]       limit;
    cccd_pkg::t_status status;

    assign o_ready  = i_space;
    assign accept   = i_valid && i_space;
    assign hp       = r_pos[4:0];
    assign seq_lane = 3'(hp - 5'd12);
    assign len_cap  = 33'd1 << PAYLOAD_LENGTH_BITS;
    assign limit    = ({8'd0, r_cfg_max_len} > len_cap) ? len_cap : {8'd0, r_cfg_max_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic    <= cccd_pkg::RST_MAGIC;
            r_cfg_version  <= cccd_pkg::RST_VERSION;
            r_cfg_max_len  <= cccd_pkg::RST_MAX_LEN;
            r_cfg_max_type <= cccd_pkg::RST_MAX_TYPE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cccd_pkg::CFG_MAGIC:    r_cfg_magic    <= i_cfg_data;
                cccd_pkg::CFG_VERSION:  r_cfg_version  <= i_cfg_data[15:0];
                cccd_pkg::CFG_MAX_LEN:  r_cfg_max_len  <= i_cfg_data[24:0];
                cccd_pkg::CFG_MAX_TYPE: r_cfg_max_type <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_pay_end = r_pay_end;
        n_trl_end = r_trl_end;
        n_magic   = r_magic;
        n_ver     = r_ver;
        n_type    = r_type;
        n_flags   = r_flags;
        n_seq     = r_seq;
        n_len     = r_len;
        n_hcrc    = r_hcrc;
        n_crc     = r_crc;
        n_trailer = r_trailer;
        n_defer   = r_defer;
        fwd       = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                case (hp) inside
                    [5'd0:5'd3]:   n_magic[{hp[1:0], 3'b000} +: 8] = i_data_byte;
                    [5'd4:5'd5]:   n_ver[{hp[0], 3'b000} +: 8]     = i_data_byte;
                    [5'd6:5'd7]:   n_type[{hp[0], 3'b000} +: 8]    = i_data_byte;
                    [5'd8:5'd11]:  n_flags[{hp[1:0], 3'b000} +: 8] = i_data_byte;
                    [5'd12:5'd19]: n_seq[{seq_lane, 3'b000} +: 8]  = i_data_byte;
                    [5'd20:5'd23]: n_len[{hp[1:0], 3'b000} +: 8]   = i_data_byte;
                    [5'd28:5'd31]: n_hcrc[{hp[1:0], 3'b000} +: 8]  = i_data_byte;
                    default: ;
                endcase
                if (hp < 5'(cccd_pkg::CRC_COVER_BYTES)) begin
                    n_crc = cccd_pkg::crc32c_byte(r_crc, i_data_byte);
                end
                n_pos = r_pos + POS_W'(1);
                if (hp == 5'(cccd_pkg::HEADER_BYTES - 1)) begin
                    n_pay_end = POS_W'(cccd_pkg::HEADER_BYTES) + POS_W'(r_len);
                    n_trl_end = n_pay_end + POS_W'(cccd_pkg::TRAILER_BYTES);
                    if (r_magic != r_cfg_magic) begin
                        n_defer = cccd_pkg::ST_BAD_MAGIC;
                        n_phase = PH_DISCARD;
                    end else if (n_hcrc != ~r_crc) begin
                        n_defer = cccd_pkg::ST_HEADER_CRC;
                        n_phase = PH_DISCARD;
                    end else if ({1'b0, r_len} > limit) begin
                        n_defer = cccd_pkg::ST_TOO_LONG;
                        n_phase = PH_DISCARD;
                    end else begin
                        if (r_ver != r_cfg_version) begin
                            n_defer = cccd_pkg::ST_VERSION;
                        end else if (r_type > r_cfg_max_type) begin
                            n_defer = cccd_pkg::ST_TYPE_TRAIL;
                        end
                        n_phase = (r_len == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                    n_crc = '1;
                end
            end
            PH_PAYLOAD: begin
                n_crc = cccd_pkg::crc32c_byte(r_crc, i_data_byte);
                fwd   = (r_defer == cccd_pkg::ST_OK);
                n_pos = r_pos + POS_W'(1);
                if (n_pos == r_pay_end) begin
                    n_phase = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                // shift in little-endian; four bytes leave the word in place
                n_trailer = {i_data_byte, r_trailer[31:8]};
                n_pos     = r_pos + POS_W'(1);
                if (n_pos == r_trl_end) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE:    n_phase = PH_EXTRA;
            PH_EXTRA:   ;
            PH_DISCARD: ;
            default:    n_phase = PH_HEADER;
        endcase
    end

    always_comb begin
        if (n_phase == PH_DISCARD) begin
            status = n_defer;
        end else if (n_phase == PH_HEADER || n_phase == PH_PAYLOAD ||
                     n_phase == PH_TRAILER) begin
            status = cccd_pkg::ST_TRUNCATED;
        end else if (n_defer != cccd_pkg::ST_OK) begin
            status = n_defer;
        end else if (n_trailer != ~n_crc) begin
            status = cccd_pkg::ST_PAYLOAD_CRC;
        end else if (n_phase == PH_EXTRA) begin
            status = cccd_pkg::ST_TYPE_TRAIL;
        end else begin
            status = cccd_pkg::ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        if (i_buffer_end) begin
            o_result.result_kind   = cccd_pkg::KIND_STATUS;
            o_result.frame_status  = status;
            o_result.last_of_frame = 1'b1;
            if (n_phase != PH_HEADER) begin
                o_result.message_type    = n_type;
                o_result.frame_flags     = n_flags;
                o_result.sequence_number = n_seq;
            end
            if (status == cccd_pkg::ST_OK) begin
                o_result.frame_total_bytes = cccd_pkg::TOTAL_W'(n_trl_end);
            end
        end else begin
            o_result.result_kind  = cccd_pkg::KIND_PAYLOAD;
            o_result.payload_byte = i_data_byte;
        end
    end

    assign o_push = accept && (i_buffer_end || fwd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_buffer_end)) begin
            r_phase   <= PH_HEADER;
            r_pos     <= '0;
            r_crc     <= '1;
            r_defer   <= cccd_pkg::ST_OK;
            r_pay_end <= '0;
            r_trl_end <= '0;
            r_len     <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_defer   <= n_defer;
            r_pay_end <= n_pay_end;
            r_trl_end <= n_trl_end;
            r_len     <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_magic   <= n_magic;
            r_ver     <= n_ver;
            r_type    <= n_type;
            r_flags   <= n_flags;
            r_seq     <= n_seq;
            r_hcrc    <= n_hcrc;
            r_trailer <= n_trailer;
        end
    end

`ifndef NO_ASSERTIONS
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.result_kind == cccd_pkg::KIND_STATUS)
        |=> (r_phase == PH_HEADER && r_pos == '0))
        else $error("frame state not cleared after status");
    a_fwd_only_clean_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.result_kind == cccd_pkg::KIND_PAYLOAD)
        |-> (r_phase == PH_PAYLOAD && r_defer == cccd_pkg::ST_OK))
        else $error("payload byte forwarded outside a clean payload");
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos < POS_W'(cccd_pkg::HEADER_BYTES)))
        else $error("header position out of range");
`endif
endmodule
`default_nettype wire

>>> hdl/cccd_queue.sv
// Back end: short result queue that decouples the parser from the output
// channel and presents the head entry. Depends on cccd_pkg.
`default_nettype none
module cccd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire cccd_pkg::t_result  i_entry,
    output logic                    o_space,
    output logic                    o_valid,
    output cccd_pkg::t_result       o_entry,
    input  wire logic               i_ready
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cccd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              pop;

    assign o_space = (r_count < CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");
    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full result queue");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count did not drop on pop");
`endif
endmodule
`default_nettype wire

>>> hdl/crc_checked_frame_deframer.sv
// Top level of the CRC-32C checked frame deframer: front parser plus result queue.
// Depends on cccd_pkg, cccd_if, cccd_front and cccd_queue.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+-----------------------------------------
//   i_in     | in  | valid/ready     | data_byte, buffer_end
//   o_out    | out | valid/ready     | result_kind, payload_byte, frame_status,
//            |     |                 | message_type, frame_flags,
//            |     |                 | sequence_number, frame_total_bytes,
//            |     |                 | last_of_frame
//   cfg      | in  | i_cfg_we only   | i_cfg_idx, i_cfg_data
//
// One byte per cycle while the queue has room: each byte is parsed and its
// CRC-32C step done in the cycle it is taken; results reach o_out via the queue.
// Synchronous active-low reset clears frame state and restores config defaults.
// Input ready depends only on room in the result queue, so a stall on o_out
// back-pressures i_in once the queue fills; otherwise bytes flow at full rate.
`default_nettype none
module crc_checked_frame_deframer #(
    parameter int PAYLOAD_LENGTH_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    cccd_in_if.sink          i_in,
    cccd_out_if.source       o_out
);
    logic              space;
    logic              push;
    cccd_pkg::t_result entry;
    cccd_pkg::t_result head;

    // Parse and classify each transaction
    cccd_front #(
        .PAYLOAD_LENGTH_BITS (PAYLOAD_LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in.valid),
        .i_data_byte  (i_in.data_byte),
        .i_buffer_end (i_in.buffer_end),
        .o_ready      (i_in.ready),
        .i_space      (space),
        .o_push       (push),
        .o_result     (entry)
    );

    // Hold results until the sink takes them
    cccd_queue #(
        .DEPTH (cccd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_space (space),
        .o_valid (o_out.valid),
        .o_entry (head),
        .i_ready (o_out.ready)
    );

    assign o_out.result_kind       = head.result_kind;
    assign o_out.payload_byte      = head.payload_byte;
    assign o_out.frame_status      = head.frame_status;
    assign o_out.message_type      = head.message_type;
    assign o_out.frame_flags       = head.frame_flags;
    assign o_out.sequence_number   = head.sequence_number;
    assign o_out.frame_total_bytes = head.frame_total_bytes;
    assign o_out.last_of_frame     = head.last_of_frame;
endmodule
`default_nettype wire

>>> verif/cccd_tb_pkg.sv
// Testbench helpers for the frame deframer: CRC-32C byte step used to build
// frames and to predict results. Depends on nothing.
`timescale 1ns / 1ps
package cccd_tb_pkg;

    localparam logic [31:0] CASTAGNOLI_REFLECTED = 32'h82F6_3B78;

    function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CASTAGNOLI_REFLECTED;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

>>> verif/crc_checked_frame_deframer_checker.sv
// Watches the byte and result channels of the deframer, predicts each result
// and compares it. Depends on cccd_pkg, cccd_if and cccd_tb_pkg.
`timescale 1ns / 1ps
module crc_checked_frame_deframer_checker #(
    parameter int LEN_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    cccd_in_if               in_ch,
    cccd_out_if              out_ch,
    output int               o_errors,
    output int               o_pending,
    output int               o_frames,
    output int               o_forwarded
);
    import cccd_pkg::*;
    import cccd_tb_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PAYLOAD, PH_TRAILER, PH_DONE, PH_EXTRA, PH_DISCARD
    } t_phase;

    logic [31:0]        magic_reg;
    logic [15:0]        version_reg;
    logic [24:0]        max_len_reg;
    logic [15:0]        max_type_reg;

    t_phase             phase;
    longint unsigned    pos;
    logic [31:0]        hdr_magic;
    logic [15:0]        hdr_version;
    logic [15:0]        hdr_type;
    logic [31:0]        hdr_flags;
    logic [63:0]        hdr_seq;
    logic [31:0]        hdr_len;
    logic [31:0]        hdr_crc;
    logic [31:0]        crc_acc;
    logic [31:0]        trailer;
    t_status            held_error;

    t_result            expected_results[$];

    assign o_pending = expected_results.size();

    function automatic void clear_frame();
        phase       = PH_HEADER;
        pos         = 0;
        hdr_magic   = '0;
        hdr_version = '0;
        hdr_type    = '0;
        hdr_flags   = '0;
        hdr_seq     = '0;
        hdr_len     = '0;
        hdr_crc     = '0;
        crc_acc     = '1;
        trailer     = '0;
        held_error  = ST_OK;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("kind=%0d byte=%h st=%0d type=%h flags=%h seq=%h total=%0d last=%0d",
                         r.result_kind, r.payload_byte, r.frame_status, r.message_type,
                         r.frame_flags, r.sequence_number, r.frame_total_bytes,
                         r.last_of_frame);
    endfunction

    // Advance the frame state by one byte; queue the result it causes.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        longint unsigned pay_end;
        longint unsigned limit;
        logic            forward;
        t_result         r;
        pay_end = HEADER_BYTES + hdr_len;
        forward = 1'b0;
        r       = '0;
        case (phase)
            PH_HEADER: begin
                if (pos < 4)       hdr_magic[8*pos +: 8]          = b;
                else if (pos < 6)  hdr_version[8*(pos-4) +: 8]    = b;
                else if (pos < 8)  hdr_type[8*(pos-6) +: 8]       = b;
                else if (pos < 12) hdr_flags[8*(pos-8) +: 8]      = b;
                else if (pos < 20) hdr_seq[8*(pos-12) +: 8]       = b;
                else if (pos < 24) hdr_len[8*(pos-20) +: 8]       = b;
                else if (pos >= 28) hdr_crc[8*(pos-28) +: 8]      = b;
                if (pos < CRC_COVER_BYTES) crc_acc = crc32c_step(crc_acc, b);
                pos++;
                if (pos == HEADER_BYTES) begin
                    // Magic, header CRC and length failures are final
                    limit = (max_len_reg > (25'd1 << LEN_BITS)) ? (64'd1 << LEN_BITS)
                                                                 : max_len_reg;
                    if (hdr_magic != magic_reg) begin
                        held_error = ST_BAD_MAGIC;
                        phase      = PH_DISCARD;
                    end else if (hdr_crc != ~crc_acc) begin
                        held_error = ST_HEADER_CRC;
                        phase      = PH_DISCARD;
                    end else if (longint'(hdr_len) > limit) begin
                        held_error = ST_TOO_LONG;
                        phase      = PH_DISCARD;
                    end else begin
                        if (hdr_version != version_reg)    held_error = ST_VERSION;
                        else if (hdr_type > max_type_reg)  held_error = ST_TYPE_TRAIL;
                        phase = (hdr_len == 0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                    crc_acc = '1;
                end
            end
            PH_PAYLOAD: begin
                crc_acc = crc32c_step(crc_acc, b);
                forward = (held_error == ST_OK);
                pos++;
                if (pos == pay_end) phase = PH_TRAILER;
            end
            PH_TRAILER: begin
                trailer[8*((pos - pay_end) & 3) +: 8] = b;
                pos++;
                if (pos == pay_end + TRAILER_BYTES) phase = PH_DONE;
            end
            PH_DONE: phase = PH_EXTRA;
            default: ;
        endcase

        if (!last) begin
            if (forward) begin
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = b;
                expected_results.push_back(r);
            end
        end else begin
            r.result_kind = KIND_STATUS;
            if (phase == PH_DISCARD)                     r.frame_status = held_error;
            else if (phase inside {PH_HEADER, PH_PAYLOAD, PH_TRAILER})
                                                          r.frame_status = ST_TRUNCATED;
            else if (held_error != ST_OK)                r.frame_status = held_error;
            else if (trailer != ~crc_acc)                r.frame_status = ST_PAYLOAD_CRC;
            else if (phase == PH_EXTRA)                  r.frame_status = ST_TYPE_TRAIL;
            else                                         r.frame_status = ST_OK;
            if (phase != PH_HEADER) begin
                r.message_type    = hdr_type;
                r.frame_flags     = hdr_flags;
                r.sequence_number = hdr_seq;
            end
            if (r.frame_status == ST_OK)
                r.frame_total_bytes = TOTAL_W'(pay_end + TRAILER_BYTES);
            r.last_of_frame = 1'b1;
            expected_results.push_back(r);
            clear_frame();
        end
    endtask

    task automatic flag_error(input string msg);
        o_errors++;
        if (o_errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    initial begin
        o_errors    = 0;
        o_frames    = 0;
        o_forwarded = 0;
        clear_frame();
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        string   bad;
        if (!i_rst_n) begin
            magic_reg    <= RST_MAGIC;
            version_reg  <= RST_VERSION;
            max_len_reg  <= RST_MAX_LEN;
            max_type_reg <= RST_MAX_TYPE;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:    magic_reg    <= i_cfg_data;
                    CFG_VERSION:  version_reg  <= i_cfg_data[15:0];
                    CFG_MAX_LEN:  max_len_reg  <= i_cfg_data[24:0];
                    CFG_MAX_TYPE: max_type_reg <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // Compare first so a result never meets the expectation of its own cycle
            if (out_ch.valid && out_ch.ready) begin
                got.result_kind       = out_ch.result_kind;
                got.payload_byte      = out_ch.payload_byte;
                got.frame_status      = out_ch.frame_status;
                got.message_type      = out_ch.message_type;
                got.frame_flags       = out_ch.frame_flags;
                got.sequence_number   = out_ch.sequence_number;
                got.frame_total_bytes = out_ch.frame_total_bytes;
                got.last_of_frame     = out_ch.last_of_frame;
                if (expected_results.size() == 0) begin
                    flag_error({"result with nothing expected: ", show(got)});
                end else begin
                    exp = expected_results.pop_front();
                    bad = "";
                    if (got.result_kind !== exp.result_kind)             bad = {bad, " kind"};
                    if (got.payload_byte !== exp.payload_byte)           bad = {bad, " byte"};
                    if (got.frame_status !== exp.frame_status)           bad = {bad, " status"};
                    if (got.message_type !== exp.message_type)           bad = {bad, " type"};
                    if (got.frame_flags !== exp.frame_flags)             bad = {bad, " flags"};
                    if (got.sequence_number !== exp.sequence_number)     bad = {bad, " seq"};
                    if (got.frame_total_bytes !== exp.frame_total_bytes) bad = {bad, " total"};
                    if (got.last_of_frame !== exp.last_of_frame)         bad = {bad, " last"};
                    if (bad != "")
                        flag_error({"mismatch in", bad, "\n  expected ", show(exp),
                                    "\n  actual   ", show(got)});
                    if (exp.result_kind == KIND_STATUS) o_frames++;
                    else                                o_forwarded++;
                end
            end
            if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.buffer_end);
        end
    end

endmodule

>>> verif/crc_checked_frame_deframer_test.sv
// Stimulus and verdict for the CRC-32C checked frame deframer: builds good and
// damaged frames, drives random idle and stall, and counts on the checker.
// Depends on cccd_pkg, cccd_if, cccd_tb_pkg and the checker module.
`timescale 1ns / 1ps
module crc_checked_frame_deframer_test;
    import cccd_pkg::*;
    import cccd_tb_pkg::*;

    // Kinds of buffer the generator can produce
    typedef enum int {
        FL_NONE, FL_MAGIC, FL_HDR_CRC, FL_LONG, FL_VERSION, FL_TYPE,
        FL_PAY_CRC, FL_TRAIL, FL_TRUNC, FL_NOISE
    } t_flaw;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    cccd_in_if  in_ch();
    cccd_out_if out_ch();

    int errors, pending, frames_seen, bytes_forwarded;

    // Shadow of the register values, used to build frames that pass or fail
    logic [31:0] cur_magic;
    logic [15:0] cur_version;
    logic [24:0] cur_max_len;
    logic [15:0] cur_max_type;

    bit  quiet;      // no idling in the closing stretch
    int  rx_hold;    // receiver hold-off length, consumed by the receiver process
    int  bytes_sent;
    int  flaw_count[t_flaw];

    crc_checked_frame_deframer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    crc_checked_frame_deframer_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_frames    (frames_seen),
        .o_forwarded (bytes_forwarded)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Hard stop in case the block hangs
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: hold off when asked, otherwise stall in short random bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready = 1'b0;
                rx_hold--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Offer one byte, idling first at random, and hold it until the transaction
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.data_byte  = b;
        in_ch.buffer_end = last;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MAGIC:    cur_magic    = value;
            CFG_VERSION:  cur_version  = value[15:0];
            CFG_MAX_LEN:  cur_max_len  = value[24:0];
            CFG_MAX_TYPE: cur_max_type = value[15:0];
            default: ;
        endcase
    endtask

    // Stop offering, wait for every expected result, then let the pipe settle
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [24:0] max_len, input logic [15:0] max_type);
        drain();
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {16'd0, ver});
        write_reg(CFG_MAX_LEN, {7'd0, max_len});
        write_reg(CFG_MAX_TYPE, {16'd0, max_type});
    endtask

    // Build a buffer with the given damage and a payload of plen bytes, then send it
    task automatic send_frame(input t_flaw flaw, input int plen);
        logic [7:0]  buffer_q[$];
        logic [31:0] magic, len_field, crc, limit;
        logic [15:0] ver, mtype;
        logic [63:0] seq;
        logic [31:0] flags;
        int          keep;
        flaw_count[flaw]++;
        if (flaw == FL_NOISE) begin
            repeat ($urandom_range(1, 40)) buffer_q.push_back($urandom);
        end else begin
            limit = (cur_max_len > 25'd16777216) ? 32'd16777216 : {7'd0, cur_max_len};
            if (plen > limit) plen = limit;
            magic = cur_magic;
            if (flaw == FL_MAGIC) magic ^= 32'd1 << $urandom_range(0, 31);
            ver = cur_version;
            if (flaw == FL_VERSION) ver ^= 16'd1 << $urandom_range(0, 15);
            if (flaw == FL_TYPE && cur_max_type != 16'hFFFF) begin
                mtype = $urandom_range(cur_max_type + 1, 16'hFFFF);
            end else begin
                case ($urandom_range(0, 3))
                    0:       mtype = 16'd0;
                    1:       mtype = cur_max_type;
                    default: mtype = $urandom_range(0, cur_max_type);
                endcase
            end
            len_field = plen;
            if (flaw == FL_LONG) len_field = $urandom_range(0, 1) ? limit + 1 : 32'hFFFF_FFFF;
            flags = $urandom;
            seq   = {$urandom, $urandom};
            for (int i = 0; i < 4; i++) buffer_q.push_back(magic[8*i +: 8]);
            for (int i = 0; i < 2; i++) buffer_q.push_back(ver[8*i +: 8]);
            for (int i = 0; i < 2; i++) buffer_q.push_back(mtype[8*i +: 8]);
            for (int i = 0; i < 4; i++) buffer_q.push_back(flags[8*i +: 8]);
            for (int i = 0; i < 8; i++) buffer_q.push_back(seq[8*i +: 8]);
            for (int i = 0; i < 4; i++) buffer_q.push_back(len_field[8*i +: 8]);
            for (int i = 0; i < 4; i++) buffer_q.push_back($urandom);
            crc = '1;
            foreach (buffer_q[i]) crc = crc32c_step(crc, buffer_q[i]);
            crc = ~crc;
            if (flaw == FL_HDR_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
            for (int i = 0; i < 4; i++) buffer_q.push_back(crc[8*i +: 8]);
            if (flaw == FL_LONG) begin
                // Whatever follows a rejected header is ignored
                repeat ($urandom_range(0, 6)) buffer_q.push_back($urandom);
            end else begin
                crc = '1;
                repeat (plen) begin
                    buffer_q.push_back($urandom);
                    crc = crc32c_step(crc, buffer_q[$]);
                end
                crc = ~crc;
                if (flaw == FL_PAY_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
                for (int i = 0; i < 4; i++) buffer_q.push_back(crc[8*i +: 8]);
                if (flaw == FL_TRAIL) repeat ($urandom_range(1, 3)) buffer_q.push_back($urandom);
                if (flaw == FL_TRUNC) begin
                    keep = $urandom_range(1, buffer_q.size() - 1);
                    while (buffer_q.size() > keep) void'(buffer_q.pop_back());
                end
            end
        end
        foreach (buffer_q[i]) send_byte(buffer_q[i], i == buffer_q.size() - 1);
    endtask

    function automatic t_flaw pick_flaw();
        if ($urandom_range(0, 99) < 55) return FL_NONE;
        return t_flaw'($urandom_range(FL_MAGIC, FL_NOISE));
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(100, 200);
        return $urandom_range(0, 24);
    endfunction

    task automatic random_run(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_frame(pick_flaw(), pick_len());
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_MAGIC;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.buffer_end = 1'b0;
        quiet            = 1'b0;
        rx_hold          = 0;
        bytes_sent       = 0;
        cur_magic        = RST_MAGIC;
        cur_version      = RST_VERSION;
        cur_max_len      = RST_MAX_LEN;
        cur_max_type     = RST_MAX_TYPE;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: every outcome at least once under the reset register values
        send_frame(FL_NONE, 0);
        send_frame(FL_NONE, 3);
        for (int f = FL_MAGIC; f <= FL_NOISE; f++) send_frame(t_flaw'(f), 4);
        send_frame(FL_TRUNC, 8);

        // Extremes: all-ones magic and version, zero limits
        set_config(32'hFFFF_FFFF, 16'hFFFF, 25'd0, 16'd0);
        send_frame(FL_NONE, 0);
        send_frame(FL_LONG, 0);
        send_frame(FL_TYPE, 0);
        send_frame(FL_VERSION, 0);

        // Limit above the counter range, widest type range
        set_config($urandom, 16'd0, 25'h1FF_FFFF, 16'hFFFF);
        send_frame(FL_NONE, 5);
        send_frame(FL_LONG, 0);
        send_frame(FL_TYPE, 2);

        // Hold the receiver off long enough to fill the queue and stall input
        set_config($urandom, $urandom, 25'd64, 16'd300);
        rx_hold = 80;
        repeat (3) send_frame(FL_NONE, 20);
        drain();

        // Random traffic across several register settings
        random_run(200);
        set_config($urandom, $urandom, $urandom_range(0, 40), $urandom);
        random_run(150);
        set_config(32'h0, 16'd1, 25'd16777216, 16'd16);
        random_run(150);

        // Closing stretch at full rate on both sides
        drain();
        quiet = 1'b1;
        random_run(150);

        drain();
        repeat (8) @(posedge i_clk);
        $display("%0d bytes sent in %0d buffers checked, %0d payload bytes forwarded",
                 bytes_sent, frames_seen, bytes_forwarded);
        $display("buffers by damage: good %0d, trunc %0d, noise %0d, other %0d",
                 flaw_count[FL_NONE], flaw_count[FL_TRUNC], flaw_count[FL_NOISE],
                 frames_seen - flaw_count[FL_NONE] - flaw_count[FL_TRUNC]
                 - flaw_count[FL_NOISE]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cccd_pkg.sv
hdl/cccd_if.sv
hdl/cccd_front.sv
hdl/cccd_queue.sv
hdl/crc_checked_frame_deframer.sv
verif/cccd_tb_pkg.sv
verif/crc_checked_frame_deframer_checker.sv
verif/crc_checked_frame_deframer_test.sv
